### hdl/pps_pkg.sv
package pps_pkg;

  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRI_W   = 8;
  localparam int JOB_W   = 4;
  localparam int TIME_W  = 21;

  typedef enum logic [4:0] {
    ST_LOAD   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_STEP   = 5'b00100,
    ST_COMMIT = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   priority_level;
    logic [BURST_W-1:0] remaining;
  } entry_t;

endpackage

### hdl/preemptive_priority_scheduler.sv
// preemptive priority scheduler
// input channel (in_*): one job per transaction, arrival time, burst length and
// priority number; jobs load at one per cycle while in_stall is low. the
// transaction with in_last_entry set closes the set (jobs beyond MAX_JOBS are
// dropped, the last flag still counts) and starts the run. in_stall stays high
// for the whole run.
// result channel (out_*): one completion record per job, in completion order;
// out_final_result marks the last record of a run. a record sits in the output
// register while out_stall is high; the next completion waits until it is taken.
// the job table lives in one memory with a single read port, and every
// scheduling decision is a scan over it at one entry per cycle while no
// zero-burst completion waits for the output register. a run has at most
// 2 * job_count + 1 decisions.
// reset: counters, time and handshake state clear at once; the job memory needs
// no clearing, only entries loaded in the current set are ever read.
module preemptive_priority_scheduler import pps_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ARR_W-1:0]   in_arrival_time,
  input  logic [BURST_W-1:0] in_burst_length,
  input  logic [PRI_W-1:0]   in_priority_level,
  input  logic               in_last_entry,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [JOB_W-1:0]   out_job_number,
  output logic [TIME_W-1:0]  out_finish_time,
  output logic [TIME_W-1:0]  out_turnaround,
  output logic [TIME_W-1:0]  out_waiting,
  output logic               out_final_result
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int SIM_W = (ARR_W + CNT_W > TIME_W) ? ARR_W + CNT_W : TIME_W;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]    job_cnt_r, job_cnt_nxt;
  logic [CNT_W-1:0]    done_cnt_r, done_cnt_nxt;
  logic [SIM_W-1:0]    t_r, t_nxt;
  logic [CNT_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic                p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]    p_idx_r, p_idx_nxt;
  logic [MAX_JOBS-1:0] done_r, done_nxt;
  logic                have_best_r, have_best_nxt;
  logic                have_na_r, have_na_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  logic [ARR_W-1:0]    best_arr_r, best_arr_nxt;
  logic [BURST_W-1:0]  best_burst_r, best_burst_nxt;
  logic [PRI_W-1:0]    best_pri_r, best_pri_nxt;
  logic [BURST_W-1:0]  best_rem_r, best_rem_nxt;
  logic [ARR_W-1:0]    na_r, na_nxt;
  logic [BURST_W-1:0]  dt_r, dt_nxt;
  logic [SIM_W-1:0]    sum_ab_r, sum_ab_nxt;

  logic                out_vld_r, out_vld_nxt;
  logic [JOB_W-1:0]    out_job_r, out_job_nxt;
  logic [TIME_W-1:0]   out_fin_r, out_fin_nxt;
  logic [TIME_W-1:0]   out_turn_r, out_turn_nxt;
  logic [TIME_W-1:0]   out_wait_r, out_wait_nxt;
  logic                out_final_r, out_final_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  entry_t              ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  entry_t              rd_entry;

  logic                out_free;
  logic                arrived;
  logic                proc_zero;
  logic                blocked;
  logic                emit;
  logic                is_final;
  logic [SIM_W-1:0]    gap;
  logic [SIM_W-1:0]    fin_time;
  logic [IDX_W+JOB_W-1:0] p_idx_ext;
  logic [IDX_W+JOB_W-1:0] best_idx_ext;

  pps_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_JOBS)
  ) u_job_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  assign out_free     = !out_vld_r || !out_stall;
  assign arrived      = SIM_W'(rd_entry.arrival) <= t_r;
  assign proc_zero    = p_vld_r && !done_r[p_idx_r] && arrived && (rd_entry.remaining == '0);
  // a zero-burst completion waits here while the output register is occupied
  assign blocked      = (state_r == ST_SCAN) && proc_zero && !out_free;
  assign ram_raddr    = blocked ? p_idx_r : scan_idx_r[IDX_W-1:0];
  assign is_final     = CNT_W'(done_cnt_r + 1'b1) == job_cnt_r;
  assign gap          = SIM_W'(na_r) - t_r;
  assign fin_time     = t_r;
  assign p_idx_ext    = {{JOB_W{1'b0}}, p_idx_r};
  assign best_idx_ext = {{JOB_W{1'b0}}, best_idx_r};

  always_comb begin
    state_nxt      = state_r;
    job_cnt_nxt    = job_cnt_r;
    done_cnt_nxt   = done_cnt_r;
    t_nxt          = t_r;
    scan_idx_nxt   = scan_idx_r;
    p_vld_nxt      = p_vld_r;
    p_idx_nxt      = p_idx_r;
    done_nxt       = done_r;
    have_best_nxt  = have_best_r;
    have_na_nxt    = have_na_r;
    best_idx_nxt   = best_idx_r;
    best_arr_nxt   = best_arr_r;
    best_burst_nxt = best_burst_r;
    best_pri_nxt   = best_pri_r;
    best_rem_nxt   = best_rem_r;
    na_nxt         = na_r;
    dt_nxt         = dt_r;
    sum_ab_nxt     = sum_ab_r;
    out_vld_nxt    = out_vld_r && out_stall;
    out_job_nxt    = out_job_r;
    out_fin_nxt    = out_fin_r;
    out_turn_nxt   = out_turn_r;
    out_wait_nxt   = out_wait_r;
    out_final_nxt  = out_final_r;
    ram_we         = 1'b0;
    ram_waddr      = best_idx_r;
    ram_wdata      = '{arrival: best_arr_r, burst: best_burst_r,
                       priority_level: best_pri_r, remaining: best_rem_r - dt_r};
    emit           = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (job_cnt_r < CNT_W'(MAX_JOBS)) begin
            ram_we      = 1'b1;
            ram_waddr   = job_cnt_r[IDX_W-1:0];
            ram_wdata   = '{arrival: in_arrival_time, burst: in_burst_length,
                            priority_level: in_priority_level,
                            remaining: in_burst_length};
            job_cnt_nxt = job_cnt_r + 1'b1;
          end
          if (in_last_entry) begin
            done_nxt      = '0;
            done_cnt_nxt  = '0;
            t_nxt         = '0;
            scan_idx_nxt  = '0;
            p_vld_nxt     = 1'b0;
            have_best_nxt = 1'b0;
            have_na_nxt   = 1'b0;
            state_nxt     = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (!blocked) begin
          p_vld_nxt = scan_idx_r < job_cnt_r;
          if (scan_idx_r < job_cnt_r) begin
            p_idx_nxt    = scan_idx_r[IDX_W-1:0];
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
        if (proc_zero && out_free) begin
          // zero burst: completes at its own arrival, nothing to wait
          emit                = 1'b1;
          out_job_nxt         = p_idx_ext[JOB_W-1:0];
          out_fin_nxt         = TIME_W'(rd_entry.arrival);
          out_turn_nxt        = '0;
          out_wait_nxt        = '0;
          done_nxt[p_idx_r]   = 1'b1;
          done_cnt_nxt        = done_cnt_r + 1'b1;
        end else if (p_vld_r && !done_r[p_idx_r] && !proc_zero) begin
          if (arrived) begin
            if (!have_best_r || rd_entry.priority_level < best_pri_r) begin
              have_best_nxt  = 1'b1;
              best_idx_nxt   = p_idx_r;
              best_arr_nxt   = rd_entry.arrival;
              best_burst_nxt = rd_entry.burst;
              best_pri_nxt   = rd_entry.priority_level;
              best_rem_nxt   = rd_entry.remaining;
            end
          end else if (!have_na_r || rd_entry.arrival < na_r) begin
            have_na_nxt = 1'b1;
            na_nxt      = rd_entry.arrival;
          end
        end
        if (!p_vld_r && scan_idx_r >= job_cnt_r) begin
          state_nxt = ST_STEP;
        end
      end

      ST_STEP: begin
        if (have_best_r) begin
          // run the chosen job up to its end or the next arrival
          if (have_na_r && gap < SIM_W'(best_rem_r)) begin
            dt_nxt = gap[BURST_W-1:0];
          end else begin
            dt_nxt = best_rem_r;
          end
          state_nxt = ST_COMMIT;
        end else if (have_na_r) begin
          t_nxt         = SIM_W'(na_r);
          scan_idx_nxt  = '0;
          p_vld_nxt     = 1'b0;
          have_best_nxt = 1'b0;
          have_na_nxt   = 1'b0;
          state_nxt     = ST_SCAN;
        end else begin
          job_cnt_nxt  = '0;
          done_cnt_nxt = '0;
          t_nxt        = '0;
          state_nxt    = ST_LOAD;
        end
      end

      ST_COMMIT: begin
        ram_we        = 1'b1;
        t_nxt         = t_r + SIM_W'(dt_r);
        scan_idx_nxt  = '0;
        p_vld_nxt     = 1'b0;
        have_best_nxt = 1'b0;
        have_na_nxt   = 1'b0;
        if (dt_r == best_rem_r) begin
          done_nxt[best_idx_r] = 1'b1;
          sum_ab_nxt           = SIM_W'(best_arr_r) + SIM_W'(best_burst_r);
          state_nxt            = ST_EMIT;
        end else begin
          state_nxt = ST_SCAN;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          emit         = 1'b1;
          out_job_nxt  = best_idx_ext[JOB_W-1:0];
          out_fin_nxt  = fin_time[TIME_W-1:0];
          out_turn_nxt = TIME_W'(t_r - SIM_W'(best_arr_r));
          out_wait_nxt = TIME_W'(t_r - sum_ab_r);
          done_cnt_nxt = done_cnt_r + 1'b1;
          state_nxt    = ST_SCAN;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    if (emit) begin
      out_vld_nxt   = 1'b1;
      out_final_nxt = is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      job_cnt_r   <= '0;
      done_cnt_r  <= '0;
      t_r         <= '0;
      scan_idx_r  <= '0;
      p_vld_r     <= 1'b0;
      done_r      <= '0;
      have_best_r <= 1'b0;
      have_na_r   <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_cnt_r   <= job_cnt_nxt;
      done_cnt_r  <= done_cnt_nxt;
      t_r         <= t_nxt;
      scan_idx_r  <= scan_idx_nxt;
      p_vld_r     <= p_vld_nxt;
      done_r      <= done_nxt;
      have_best_r <= have_best_nxt;
      have_na_r   <= have_na_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r      <= p_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_arr_r   <= best_arr_nxt;
    best_burst_r <= best_burst_nxt;
    best_pri_r   <= best_pri_nxt;
    best_rem_r   <= best_rem_nxt;
    na_r         <= na_nxt;
    dt_r         <= dt_nxt;
    sum_ab_r     <= sum_ab_nxt;
    out_job_r    <= out_job_nxt;
    out_fin_r    <= out_fin_nxt;
    out_turn_r   <= out_turn_nxt;
    out_wait_r   <= out_wait_nxt;
    out_final_r  <= out_final_nxt;
  end

  assign in_stall         = state_r != ST_LOAD;
  assign out_valid        = out_vld_r;
  assign out_job_number   = out_job_r;
  assign out_finish_time  = out_fin_r;
  assign out_turnaround   = out_turn_r;
  assign out_waiting      = out_wait_r;
  assign out_final_result = out_final_r;

  a_done_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    done_cnt_r <= job_cnt_r)
    else $error("more completions than loaded jobs");

  a_run_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP && !have_best_r && !have_na_r) |-> done_cnt_r == job_cnt_r)
    else $error("run ended with unfinished jobs");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !(out_vld_r && out_stall))
    else $error("record written over a stalled record");

  a_scan_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !ram_we)
    else $error("job memory written during a scan");

endmodule

### hdl/pps_ram.sv
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
